// ===== hw/rtl/zste_pkg.sv =====
package zste_pkg;

  localparam int SPRITE_COUNT = 128;
  localparam int SPR_IDX_W    = 7;
  localparam int MEM_DEPTH    = SPRITE_COUNT * 4;
  localparam int MEM_AW       = SPR_IDX_W + 2;
  localparam int PRI_SLOTS    = 128;
  localparam int PRI_W        = 7;

  localparam int IN_W  = 56;
  localparam int OUT_W = 104;

  localparam logic [22:0] RECIP_DIVIDEND = 23'h400000;
  localparam logic [22:0] PLAIN_ZOOM     = 23'h010000;
  localparam logic [22:0] UNIT_RECIP     = 23'h010000;
  localparam logic [25:0] ROUND_HALF     = 26'd2048;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_BUILD  = 2'd1,
    OP_EXPAND = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BUILD,
    S_LOOKUP,
    S_FETCH,
    S_DIVIDE,
    S_SETUP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic                 we;
    logic [MEM_AW-1:0]    waddr;
    logic [31:0]          wdata;
    logic                 re;
    logic [MEM_AW-1:0]    raddr;
  } mem_ctl_t;

  typedef struct packed {
    logic                 clear_all;
    logic                 we;
    logic [PRI_W-1:0]     wslot;
    logic [SPR_IDX_W-1:0] windex;
    logic                 re;
    logic [PRI_W-1:0]     rslot;
  } tab_ctl_t;

  function automatic logic [4:0] x_off(input logic [2:0] i);
    x_off = {i[2], 1'b0, i[1], 1'b0, i[0]};
  endfunction

  function automatic logic [5:0] y_off(input logic [2:0] i);
    y_off = {i[2], 1'b0, i[1], 1'b0, i[0], 1'b0};
  endfunction

endpackage

// ===== hw/rtl/zoomed_sprite_tile_expander.sv =====
// Sprite list engine: keeps 128 four-word sprite records and turns one
// sprite at a time into tile draw commands.
// Input channel s_*: one word per operation. A write stores one record
// word, a build rescans all records into the 128-slot priority table, and
// an expand emits up to 64 tile commands for the sprite in one slot.
// Output channel m_*: one tile command per word, tlast on the final one.
// A build reads one record from the sprite memory port per cycle. An
// expand first does its setup (slot lookup, four record reads, reciprocal
// divide) and then issues one tile per cycle while the receiver accepts.
// Empty slots and zero scales finish with no tile command.
// Reset clears the priority table at once and then sweeps the 512-word
// sprite memory to zero, one word per cycle; s_tready stays low during
// the sweep. When the receiver stalls, the output register holds its word
// and tile generation pauses; the next operation is taken as soon as the
// last tile of a sprite is loaded into the output register.
module zoomed_sprite_tile_expander (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // op[1:0], sprite_index[8:2], word_select[10:9], word_data[42:11],
  // priority_req[49:43], zero fill above
  input  logic [55:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tile_code[16:0], color[20:17], flip_x[21], flip_y[22], pos_x[39:23],
  // pos_y[56:40], zoomed[57], zoom_x[80:58], zoom_y[103:81]
  output logic [103:0] m_tdata,
  output logic         m_tlast
);
  import zste_pkg::*;

  state_t state, state_next;
  mem_ctl_t mctl;
  tab_ctl_t tctl;
  logic [31:0] mem_rdata;
  logic look_valid;
  logic [SPR_IDX_W-1:0] tab_index;

  op_t op;
  logic in_acc;
  logic [SPR_IDX_W-1:0] in_idx;
  logic [1:0] in_sel;
  logic [31:0] in_data;
  logic [PRI_W-1:0] in_pri;

  logic [MEM_AW-1:0] clr_cnt;
  logic [SPR_IDX_W:0] bld_cnt;
  logic bld_pend;
  logic [SPR_IDX_W-1:0] bld_idx;
  logic [SPR_IDX_W-1:0] spr_idx;
  logic [2:0] fc;

  logic [15:0] code;
  logic fx, fy;
  logic [1:0] size_sel;
  logic [15:0] w1x, w1y, xsc, ysc;
  logic [3:0] color;

  logic div_start, busy_x, busy_y;
  logic [22:0] rx, ry;
  logic [16:0] ox, oy;
  logic zoomed;
  logic [2:0] xc, yc;
  logic [25:0] accx, accy;
  logic gen_fire;

  logic m_tlast_next;
  logic [2:0] smax;

  assign op      = op_t'(s_tdata[1:0]);
  assign in_idx  = s_tdata[8:2];
  assign in_sel  = s_tdata[10:9];
  assign in_data = s_tdata[42:11];
  assign in_pri  = s_tdata[49:43];
  assign in_acc  = s_tvalid && s_tready;

  zste_obj_mem u_mem (.clk(clk), .ctl(mctl), .rdata(mem_rdata));

  zste_pri_table u_tab (
    .clk(clk), .rst(rst), .ctl(tctl), .look_valid(look_valid), .rd_index(tab_index)
  );

  zste_recip u_rx (
    .clk(clk), .rst(rst), .start(div_start), .divisor(xsc), .busy(busy_x), .quotient(rx)
  );
  zste_recip u_ry (
    .clk(clk), .rst(rst), .start(div_start), .divisor(ysc), .busy(busy_y), .quotient(ry)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_cnt == MEM_AW'(MEM_DEPTH - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (in_acc && op == OP_BUILD) begin
          state_next = S_BUILD;
        end else if (in_acc && op == OP_EXPAND && look_valid) begin
          state_next = S_LOOKUP;
        end
      end
      S_BUILD:  if (bld_cnt[SPR_IDX_W]) state_next = S_IDLE;
      S_LOOKUP: state_next = S_FETCH;
      S_FETCH: begin
        if (fc == 3'd4) begin
          state_next = (xsc == '0 || ysc == '0) ? S_IDLE : S_DIVIDE;
        end
      end
      S_DIVIDE: if (!busy_x && !busy_y) state_next = S_SETUP;
      S_SETUP:  state_next = S_EMIT;
      S_EMIT:   if (gen_fire && m_tlast_next) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  assign smax = 3'((4'd1 << size_sel) - 4'd1);
  assign m_tlast_next = (xc == smax) && (yc == smax);

  // Strobes and memory port control.
  always_comb begin
    s_tready  = 1'b0;
    mctl      = '0;
    tctl      = '0;
    div_start = 1'b0;
    gen_fire  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mctl.we    = 1'b1;
        mctl.waddr = clr_cnt;
      end
      S_IDLE: begin
        s_tready       = 1'b1;
        mctl.we        = in_acc && op == OP_WRITE;
        mctl.waddr     = {in_idx, in_sel};
        mctl.wdata     = in_data;
        tctl.clear_all = in_acc && op == OP_BUILD;
        tctl.re        = in_acc && op == OP_EXPAND;
        tctl.rslot     = in_pri;
      end
      S_BUILD: begin
        mctl.re     = !bld_cnt[SPR_IDX_W];
        mctl.raddr  = {bld_cnt[SPR_IDX_W-1:0], 2'b00};
        tctl.we     = bld_pend && mem_rdata[15] && !mem_rdata[31];
        tctl.wslot  = mem_rdata[PRI_W-1:0];
        tctl.windex = bld_idx;
      end
      S_FETCH: begin
        mctl.re    = !fc[2];
        mctl.raddr = {spr_idx, fc[1:0]};
        div_start  = fc == 3'd4 && xsc != '0 && ysc != '0;
      end
      S_EMIT:  gen_fire = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + MEM_AW'(1);
      end
    end
  end

  // Build scan and record fetch sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      bld_pend <= 1'b0;
      bld_cnt  <= '0;
      fc       <= '0;
    end else begin
      bld_pend <= mctl.re && state == S_BUILD;
      if (state == S_BUILD) begin
        bld_cnt <= bld_cnt + (SPR_IDX_W + 1)'(1);
      end else begin
        bld_cnt <= '0;
      end
      if (state == S_FETCH) begin
        fc <= fc + 3'd1;
      end else begin
        fc <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    bld_idx <= bld_cnt[SPR_IDX_W-1:0];
    if (state == S_LOOKUP) begin
      spr_idx <= tab_index;
    end
    if (state == S_FETCH) begin
      unique case (fc)
        3'd1: begin
          code     <= mem_rdata[31:16];
          fy       <= mem_rdata[11];
          fx       <= mem_rdata[10];
          size_sel <= mem_rdata[9:8];
        end
        3'd2: begin
          w1y <= mem_rdata[31:16];
          w1x <= mem_rdata[15:0];
        end
        3'd3: begin
          xsc <= mem_rdata[31:16];
          ysc <= mem_rdata[15:0];
        end
        3'd4:    color <= mem_rdata[19:16];
        default: ;
      endcase
    end
  end

  // Tile generation: x outer, y inner, positions from running products.
  logic [2:0]  xi, yi;
  logic [16:0] tcode;
  logic [25:0] rx_w, ry_w;
  logic [13:0] ax0, ax1, ay0, ay1, dx, dy;
  logic [16:0] sx, sy;
  logic [22:0] zx, zy;

  assign rx_w  = 26'(rx);
  assign ry_w  = 26'(ry);
  assign xi    = fx ? smax - xc : xc;
  assign yi    = fy ? smax - yc : yc;
  assign tcode = 17'(code) + 17'(x_off(xi)) + 17'(y_off(yi));
  assign ax0   = 14'((accx + ROUND_HALF) >> 12);
  assign ax1   = 14'((accx + rx_w + ROUND_HALF) >> 12);
  assign ay0   = 14'((accy + ROUND_HALF) >> 12);
  assign ay1   = 14'((accy + ry_w + ROUND_HALF) >> 12);
  assign dx    = ax1 - ax0;
  assign dy    = ay1 - ay0;

  always_comb begin
    if (zoomed) begin
      sx = ox + 17'(ax0);
      sy = oy + 17'(ay0);
      zx = {dx[10:0], 12'b0};
      zy = {dy[10:0], 12'b0};
    end else begin
      sx = ox + 17'({xc, 4'b0});
      sy = oy + 17'({yc, 4'b0});
      zx = PLAIN_ZOOM;
      zy = PLAIN_ZOOM;
    end
  end

  logic [25:0] offx_w, offy_w;
  assign offx_w = (rx_w << size_sel) >> 13;
  assign offy_w = (ry_w << size_sel) >> 13;

  always_ff @(posedge clk) begin
    if (state == S_SETUP) begin
      ox     <= {w1x[15], w1x} - 17'(offx_w);
      oy     <= {w1y[15], w1y} - 17'(offy_w);
      zoomed <= rx != UNIT_RECIP || ry != UNIT_RECIP;
      xc     <= '0;
      yc     <= '0;
      accx   <= '0;
      accy   <= '0;
    end else if (gen_fire) begin
      if (yc == smax) begin
        yc   <= '0;
        accy <= '0;
        xc   <= xc + 3'd1;
        accx <= accx + rx_w;
      end else begin
        yc   <= yc + 3'd1;
        accy <= accy + ry_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (gen_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_fire) begin
      m_tdata <= {zy, zx, zoomed, sy, sx, fy, fx, color, tcode};
      m_tlast <= m_tlast_next;
    end
  end

endmodule

// ===== hw/rtl/zste_obj_mem.sv =====
module zste_obj_mem (
  input  logic              clk,
  input  zste_pkg::mem_ctl_t ctl,
  output logic [31:0]       rdata
);
  import zste_pkg::*;

  logic [31:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata <= mem[ctl.raddr];
    end
  end

endmodule

// ===== hw/rtl/zste_pri_table.sv =====
module zste_pri_table (
  input  logic                          clk,
  input  logic                          rst,
  input  zste_pkg::tab_ctl_t            ctl,
  output logic                          look_valid,
  output logic [zste_pkg::SPR_IDX_W-1:0] rd_index
);
  import zste_pkg::*;

  logic [PRI_SLOTS-1:0] slot_valid;
  logic [SPR_IDX_W-1:0] index_mem [PRI_SLOTS];

  always_ff @(posedge clk) begin
    if (rst || ctl.clear_all) begin
      slot_valid <= '0;
    end else if (ctl.we) begin
      slot_valid[ctl.wslot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      index_mem[ctl.wslot] <= ctl.windex;
    end
    if (ctl.re) begin
      rd_index <= index_mem[ctl.rslot];
    end
  end

  assign look_valid = slot_valid[ctl.rslot];

endmodule

// ===== hw/rtl/zste_recip.sv =====
module zste_recip (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [22:0] quotient
);
  import zste_pkg::*;

  logic [15:0] rem;
  logic [15:0] dvs;
  logic [4:0]  count;
  logic [16:0] rem_sh;
  logic        fits;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh = {rem, quotient[22]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= 5'd23;
    end else if (busy) begin
      count <= count - 5'd1;
      busy  <= count != 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= RECIP_DIVIDEND;
    end else if (busy) begin
      rem      <= fits ? 16'(rem_sh - {1'b0, dvs}) : rem_sh[15:0];
      quotient <= {quotient[21:0], fits};
    end
  end

endmodule

// ===== hw/rtl/zste_checker.sv =====
module zste_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [55:0]  s_tdata,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata,
  input logic         m_tlast
);
  import zste_pkg::*;

  // A stalled output word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output word changed");

  // No new operation is taken in the middle of a sprite.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input taken during tile burst");

  // Writes, builds and unused ops create no output.
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata[1:0] != OP_EXPAND && !m_tvalid |=> !m_tvalid)
    else $error("output without expand");

  // The memory clearing pass follows reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("block active right after reset");

endmodule

bind zoomed_sprite_tile_expander zste_checker u_zste_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
